### rtl/sss_pkg.sv
package sss_pkg;

    // Input request: four Q0.32 uniform fractions
    typedef struct packed {
        logic [31:0] rand_pos_a;
        logic [31:0] rand_pos_b;
        logic [31:0] rand_dir_a;
        logic [31:0] rand_dir_b;
    } t_in_req;

    // Result request: point in Q16.16, direction in Q1.30, flip flag
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] dir_u;
        logic signed [31:0] dir_v;
        logic signed [31:0] dir_w;
        logic               was_flipped;
    } t_out_req;

    // Register word indexes
    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_TARGET_X = 2'd1;
    localparam logic [1:0] REG_TARGET_Y = 2'd2;
    localparam logic [1:0] REG_TARGET_Z = 2'd3;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    // Iteration array: enough steps for the 31-step square root and up to 32 rotations
    localparam int ITER_STAGES = 32;
    localparam int SQRT_STEPS  = 31;

    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [33:0] CORDIC_INIT = 34'sd652032874;

    // Rotation angles, atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933405;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41721;
            5'd15: v = 30'd20860;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2607;
            5'd19: v = 30'd1303;
            5'd20: v = 30'd651;
            5'd21: v = 30'd325;
            5'd22: v = 30'd162;
            5'd23: v = 30'd81;
            5'd24: v = 30'd40;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd2;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/sphere_surface_source_sampler_top.sv
// Sphere surface source sampler: each request of four random fractions gives one
// point on a sphere of programmed radius and one direction facing the target point.
// The block takes one request per cycle while the result side does not stall, and passes
// each through one input stage, 32 iteration stages that run the sin/cos rotations and
// the bit-serial square root side by side, and five stages of products, scaling,
// dot product and flip. The output register holds a result while the far side
// stalls; the whole pipeline then holds. Program the registers only while idle.
module sphere_surface_source_sampler_top #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sss_pkg::t_in_req   i_in_req,
    // Result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sss_pkg::t_out_req  o_out_req,
    // Register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sss_pkg::*;

    localparam int L = ITER_STAGES;
    localparam int NROT = (CORDIC_STAGES > ITER_STAGES) ? ITER_STAGES : CORDIC_STAGES;

    // Helpers
    function automatic logic signed [31:0] clamp30(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'(Q30_ONE))       r = 32'(Q30_ONE);
        else if (v < -36'(Q30_ONE)) r = -32'(Q30_ONE);
        else                        r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [35:0] mulq30(input logic signed [32:0] a,
                                                  input logic signed [31:0] b);
        logic signed [64:0] p;
        p = 65'(a) * 65'(b) + 65'sd536870912;
        return 36'(p >>> 30);
    endfunction

    // Configuration registers
    logic [30:0]        r_radius;
    logic signed [31:0] r_tx, r_ty, r_tz;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_tx     <= '0;
            r_ty     <= '0;
            r_tz     <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_RADIUS:   r_radius <= pwdata[30:0];
                REG_TARGET_X: r_tx     <= pwdata;
                REG_TARGET_Y: r_ty     <= pwdata;
                REG_TARGET_Z: r_tz     <= pwdata;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[3:2])
            REG_RADIUS:   prdata = {1'b0, r_radius};
            REG_TARGET_X: prdata = r_tx;
            REG_TARGET_Y: prdata = r_ty;
            REG_TARGET_Z: prdata = r_tz;
        endcase
    end

    // Advance the whole pipeline unless a held result is stalled
    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // Iteration array state; lane 0 is position, lane 1 is direction
    logic                r_v   [0:L];
    logic signed [33:0]  r_x   [0:L][0:1];
    logic signed [33:0]  r_y   [0:L][0:1];
    logic signed [33:0]  r_z   [0:L][0:1];
    logic [61:0]         r_n   [0:L][0:1];
    logic [61:0]         r_res [0:L][0:1];
    logic signed [31:0]  r_ct  [0:L][0:1];
    logic [1:0]          r_q   [0:L][0:1];

    // Input stage: split angle, form c and 1 - c*c
    logic [31:0] in_a [0:1];
    logic [31:0] in_b [0:1];
    assign in_a[0] = i_in_req.rand_pos_a;
    assign in_b[0] = i_in_req.rand_pos_b;
    assign in_a[1] = i_in_req.rand_dir_a;
    assign in_b[1] = i_in_req.rand_dir_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (en)  r_v[0] <= i_in_valid;
    end

    for (genvar j = 0; j < 2; j++) begin : g_in
        logic signed [31:0] ct;
        logic signed [63:0] ct2;
        assign ct  = $signed({1'b0, in_b[j][31:1]}) - 32'sd1073741824;
        assign ct2 = 64'(ct) * 64'(ct);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x[0][j]   <= CORDIC_INIT;
                r_y[0][j]   <= '0;
                r_z[0][j]   <= {4'b0, in_a[j][29:0]};
                r_q[0][j]   <= in_a[j][31:30];
                r_ct[0][j]  <= ct;
                r_n[0][j]   <= (62'd1 << 60) - ct2[61:0];
                r_res[0][j] <= '0;
            end
        end
    end

    // Iteration stages: a rotation in each of the first NROT, a square root step in each of the first SQRT_STEPS
    for (genvar k = 0; k < L; k++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k+1] <= 1'b0;
            else if (en)  r_v[k+1] <= r_v[k];
        end
        for (genvar j = 0; j < 2; j++) begin : g_lane
            logic signed [33:0] nx, ny, nz;
            logic [61:0]        nn, nres;

            if (k < NROT) begin : g_rot
                logic signed [33:0] dx, dy, at;
                assign dx = r_y[k][j] >>> k;
                assign dy = r_x[k][j] >>> k;
                assign at = {4'b0, atan_turn(5'(k))};
                always_comb begin
                    if (r_z[k][j] >= 0) begin
                        nx = r_x[k][j] - dx;
                        ny = r_y[k][j] + dy;
                        nz = r_z[k][j] - at;
                    end else begin
                        nx = r_x[k][j] + dx;
                        ny = r_y[k][j] - dy;
                        nz = r_z[k][j] + at;
                    end
                end
            end else begin : g_norot
                assign nx = r_x[k][j];
                assign ny = r_y[k][j];
                assign nz = r_z[k][j];
            end

            if (k < SQRT_STEPS) begin : g_sq
                logic [61:0] bt, t;
                assign bt = 62'd1 << (60 - 2 * k);
                assign t  = r_res[k][j] + bt;
                always_comb begin
                    if (r_n[k][j] >= t) begin
                        nn   = r_n[k][j] - t;
                        nres = (r_res[k][j] >> 1) + bt;
                    end else begin
                        nn   = r_n[k][j];
                        nres = r_res[k][j] >> 1;
                    end
                end
            end else begin : g_nosq
                assign nn   = r_n[k][j];
                assign nres = r_res[k][j];
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_x[k+1][j]   <= nx;
                    r_y[k+1][j]   <= ny;
                    r_z[k+1][j]   <= nz;
                    r_n[k+1][j]   <= nn;
                    r_res[k+1][j] <= nres;
                    r_ct[k+1][j]  <= r_ct[k][j];
                    r_q[k+1][j]   <= r_q[k][j];
                end
            end
        end
    end

    // Stage A: clamp and unfold quadrant
    logic               r_va;
    logic signed [31:0] r_sp [0:1];
    logic signed [31:0] r_cp [0:1];
    logic signed [31:0] r_cta[0:1];
    logic signed [31:0] r_st [0:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (en)  r_va <= r_v[L];
    end

    for (genvar j = 0; j < 2; j++) begin : g_sa
        logic signed [31:0] c, s, sp, cp;
        assign c = clamp30(36'(r_x[L][j]));
        assign s = clamp30(36'(r_y[L][j]));
        always_comb begin
            unique case (r_q[L][j])
                2'd0: begin cp = c;  sp = s;  end
                2'd1: begin cp = -s; sp = c;  end
                2'd2: begin cp = -c; sp = -s; end
                2'd3: begin cp = s;  sp = -c; end
            endcase
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sp[j]  <= sp;
                r_cp[j]  <= cp;
                r_cta[j] <= r_ct[L][j];
                r_st[j]  <= $signed(r_res[L][j][31:0]);
            end
        end
    end

    // Stage B: unit vectors
    logic               r_vb;
    logic signed [31:0] r_pu [0:1][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else if (en)  r_vb <= r_va;
    end

    for (genvar j = 0; j < 2; j++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pu[j][0] <= clamp30(mulq30(33'(r_cta[j]), r_sp[j]));
                r_pu[j][1] <= clamp30(mulq30(33'(r_st[j]), r_sp[j]));
                r_pu[j][2] <= r_cp[j];
            end
        end
    end

    // Stage C: scale position by radius, saturate
    logic               r_vc;
    logic signed [31:0] r_pos [0:2];
    logic signed [31:0] r_duc [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else if (en)  r_vc <= r_vb;
    end

    for (genvar m = 0; m < 3; m++) begin : g_sc
        logic signed [35:0] p;
        assign p = mulq30($signed({2'b0, r_radius}), r_pu[0][m]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (p > 36'sd2147483647)       r_pos[m] <= 32'sh7FFFFFFF;
                else if (p < -36'sd2147483648) r_pos[m] <= 32'sh80000000;
                else                           r_pos[m] <= p[31:0];
                r_duc[m] <= r_pu[1][m];
            end
        end
    end

    // Stage D: difference to target and per-axis products
    logic               r_vd;
    logic               r_nz;
    logic signed [64:0] r_prod [0:2];
    logic signed [31:0] r_posd [0:2];
    logic signed [31:0] r_dud  [0:2];
    logic signed [32:0] dd     [0:2];

    assign dd[0] = 33'(r_tx) - 33'(r_pos[0]);
    assign dd[1] = 33'(r_ty) - 33'(r_pos[1]);
    assign dd[2] = 33'(r_tz) - 33'(r_pos[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= 1'b0;
        else if (en)  r_vd <= r_vc;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_nz <= (dd[0] != 0) || (dd[1] != 0) || (dd[2] != 0);
    end

    for (genvar m = 0; m < 3; m++) begin : g_sd
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_prod[m] <= 65'(dd[m]) * 65'(r_duc[m]);
                r_posd[m] <= r_pos[m];
                r_dud[m]  <= r_duc[m];
            end
        end
    end

    // Stage E: sign of the dot product, flip, hold result
    logic signed [66:0] dot;
    logic               flip;
    t_out_req           r_out;

    assign dot  = 67'(r_prod[0]) + 67'(r_prod[1]) + 67'(r_prod[2]);
    assign flip = r_nz && (dot <= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (en)  r_out_valid <= r_vd;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.pos_x       <= r_posd[0];
            r_out.pos_y       <= r_posd[1];
            r_out.pos_z       <= r_posd[2];
            r_out.dir_u       <= flip ? -r_dud[0] : r_dud[0];
            r_out.dir_v       <= flip ? -r_dud[1] : r_dud[1];
            r_out.dir_w       <= flip ? -r_dud[2] : r_dud[2];
            r_out.was_flipped <= flip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

### bench/sphere_surface_source_sampler_top_test.sv
`timescale 1ns / 100ps

module sphere_surface_source_sampler_top_test;
    import sss_pkg::*;

    localparam int NUM_STAGES = 24;
    localparam int LATENCY    = 38;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_req     i_in_req = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_req    o_out_req;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sphere_surface_source_sampler_top #(.CORDIC_STAGES(NUM_STAGES)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_req(i_in_req),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_req(o_out_req),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // Model copy of the registers
    logic [30:0]    radius_q16;
    longint         tgt_x, tgt_y, tgt_z;
    t_out_req       expected_samples[$];
    int             error_count = 0;
    int             result_count = 0;
    int             flip_count = 0;
    longint         cycle_count = 0;
    bit             hold_off = 1'b0;
    bit             stall_enable = 1'b1;

    localparam longint ATAN_TURNS[32] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
        10, 5, 2, 1, 0, 0};

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint root60(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 60;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // Rotate by the low 30 bits, then fold in the quadrant
    function automatic void turn_sin_cos(input logic [31:0] a, output longint sn,
                                         output longint cs);
        longint x, y, z, dx, dy, c, s;
        x = 652032874;
        y = 0;
        z = longint'(a[29:0]);
        for (int i = 0; i < (NUM_STAGES > 32 ? 32 : NUM_STAGES); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TURNS[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TURNS[i];
            end
        end
        c = clip(x, -ONE_Q30, ONE_Q30);
        s = clip(y, -ONE_Q30, ONE_Q30);
        case (a[31:30])
            2'd0: begin cs = c;  sn = s;  end
            2'd1: begin cs = -s; sn = c;  end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endfunction

    function automatic void unit_vector(input logic [31:0] ra, input logic [31:0] rb,
                                        output longint vx, output longint vy,
                                        output longint vz);
        longint sp, cp, ct, st;
        turn_sin_cos(ra, sp, cp);
        ct = longint'(rb >> 1) - ONE_Q30;
        st = root60((64'd1 << 60) - longint'(ct * ct));
        vx = clip(round_q30(ct, sp), -ONE_Q30, ONE_Q30);
        vy = clip(round_q30(st, sp), -ONE_Q30, ONE_Q30);
        vz = cp;
    endfunction

    function automatic t_out_req predict_sample(t_in_req req);
        longint pu[3], du[3], pos[3], d[3], p1, p2, p3, s;
        bit flip;
        t_out_req r;
        unit_vector(req.rand_pos_a, req.rand_pos_b, pu[0], pu[1], pu[2]);
        unit_vector(req.rand_dir_a, req.rand_dir_b, du[0], du[1], du[2]);
        for (int k = 0; k < 3; k++)
            pos[k] = clip(round_q30(longint'(radius_q16), pu[k]),
                          -64'sd2147483648, 64'sd2147483647);
        d[0] = tgt_x - pos[0];
        d[1] = tgt_y - pos[1];
        d[2] = tgt_z - pos[2];
        flip = 1'b0;
        if (d[0] != 0 || d[1] != 0 || d[2] != 0) begin
            p1 = d[0] * du[0];
            p2 = d[1] * du[1];
            p3 = d[2] * du[2];
            s = p1 + p2;
            if (s > 0 && p3 > 0) flip = 1'b0;
            else if (s < 0 && p3 < 0) flip = 1'b1;
            else flip = (s + p3) <= 0;
        end
        if (flip)
            for (int k = 0; k < 3; k++) du[k] = -du[k];
        r.pos_x = pos[0][31:0];
        r.pos_y = pos[1][31:0];
        r.pos_z = pos[2][31:0];
        r.dir_u = du[0][31:0];
        r.dir_v = du[1][31:0];
        r.dir_w = du[2][31:0];
        r.was_flipped = flip;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d want %0d", result_count, what, got, want);
        error_count++;
    endtask

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results pending", expected_samples.size());
            $display("sphere_surface_source_sampler_top_test: done, errors");
            $finish;
        end
    end

    // Drive the receiver stall: random stalls unless held off, none while disabled
    always @(posedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else if (!stall_enable) i_out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 3) i_out_stall <= 1'b1;
        else if ($urandom_range(0, 99) < 30) i_out_stall <= ($urandom_range(0, 99) < 25);
    end

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_samples.pop_front();
                if (o_out_req.pos_x !== want.pos_x)
                    report_mismatch("pos_x", o_out_req.pos_x, want.pos_x);
                if (o_out_req.pos_y !== want.pos_y)
                    report_mismatch("pos_y", o_out_req.pos_y, want.pos_y);
                if (o_out_req.pos_z !== want.pos_z)
                    report_mismatch("pos_z", o_out_req.pos_z, want.pos_z);
                if (o_out_req.dir_u !== want.dir_u)
                    report_mismatch("dir_u", o_out_req.dir_u, want.dir_u);
                if (o_out_req.dir_v !== want.dir_v)
                    report_mismatch("dir_v", o_out_req.dir_v, want.dir_v);
                if (o_out_req.dir_w !== want.dir_w)
                    report_mismatch("dir_w", o_out_req.dir_w, want.dir_w);
                if (o_out_req.was_flipped !== want.was_flipped)
                    report_mismatch("was_flipped", o_out_req.was_flipped, want.was_flipped);
                if (want.was_flipped) flip_count++;
            end
            result_count++;
        end
    end

    // Offer one request, hold it until taken, then maybe leave a gap
    task automatic send_request(input t_in_req req, input bit allow_gap);
        int gap;
        i_in_req <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_samples.push_back(predict_sample(req));
        gap = 0;
        if (allow_gap) begin
            if ($urandom_range(0, 99) < 3) gap = $urandom_range(10, 60);
            else if ($urandom_range(0, 99) < 30) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Register write in a setup and an access phase, then read back
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        logic [31:0] want_rd;
        want_rd = (index == REG_RADIUS) ? {1'b0, value[30:0]} : value;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {index, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (index)
            REG_RADIUS:   radius_q16 = value[30:0];
            REG_TARGET_X: tgt_x = longint'(signed'(value));
            REG_TARGET_Y: tgt_y = longint'(signed'(value));
            default:      tgt_z = longint'(signed'(value));
        endcase
        @(posedge i_clk);
        if (prdata !== want_rd) report_mismatch("readback", prdata, want_rd);
    endtask

    task automatic set_geometry(input logic [31:0] r, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] z);
        write_register(REG_RADIUS, r);
        write_register(REG_TARGET_X, x);
        write_register(REG_TARGET_Y, y);
        write_register(REG_TARGET_Z, z);
    endtask

    function automatic t_in_req random_request();
        t_in_req req;
        req.rand_pos_a = $urandom();
        req.rand_pos_b = $urandom();
        req.rand_dir_a = $urandom();
        req.rand_dir_b = $urandom();
        // Favor edge fractions now and then
        if ($urandom_range(0, 9) == 0) req.rand_pos_b = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 9) == 0) req.rand_dir_b = $urandom_range(0, 1) ? 32'h8000_0000 : '0;
        if ($urandom_range(0, 9) == 0) req.rand_pos_a = {2'($urandom_range(0, 3)), 30'd0};
        return req;
    endfunction

    // Field extremes, the zero-difference and zero-dot cases, and radius extremes
    task automatic test_directed();
        logic [31:0] edge_vals[6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                                      32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF};
        t_in_req req;
        for (int i = 0; i < 6; i++) begin
            req = '{edge_vals[i], edge_vals[(i + 1) % 6],
                    edge_vals[(i + 2) % 6], edge_vals[(i + 3) % 6]};
            send_request(req, 1'b0);
        end
        drain_results();
        // Target on the sampled point: pos_a = 0 puts the point at (0, 0, R)
        set_geometry(32'd65536, 32'd0, 32'd0, 32'd65536);
        send_request('{32'h0, 32'h8000_0000, 32'h1234_5678, 32'h9ABC_DEF0}, 1'b0);
        // Direction along x with the point again on the target: dot product zero
        send_request('{32'h0, 32'h8000_0000, 32'h4000_0000, 32'hFFFF_FFFF}, 1'b0);
        drain_results();
        // Radius extremes with targets at the range ends
        set_geometry(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 6; i++)
            send_request('{edge_vals[i], edge_vals[5 - i], $urandom(), edge_vals[i]}, 1'b0);
        drain_results();
        set_geometry(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) send_request(random_request(), 1'b0);
        drain_results();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 300 == 0) begin
                drain_results();
                set_geometry($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000),
                             $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 262144) - 131072,
                             $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 262144) - 131072,
                             $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 262144) - 131072);
            end
            // Some stretches run with no gaps at all
            send_request(random_request(), (i / 100) % 3 != 0);
        end
        drain_results();
    endtask

    // Long receiver hold while requests keep coming, then a pause to drain and a run with no receiver stalls
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (150) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 80; i++) send_request(random_request(), 1'b0);
        join
        drain_results();
        stall_enable = 1'b0;
        for (int i = 0; i < 60; i++) send_request(random_request(), 1'b0);
        drain_results();
        stall_enable = 1'b1;
    endtask

    initial begin
        radius_q16 = RADIUS_RESET;
        tgt_x = 0; tgt_y = 0; tgt_z = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1600);
        test_backpressure();
        set_geometry(32'd65536, 32'd0, 32'd0, 32'd0);
        test_random(100);
        $display("covered %0d results over several radius and target settings, %0d flipped",
                 result_count, flip_count);
        if (error_count == 0) begin
            $display("sphere_surface_source_sampler_top_test: done, clean");
        end else begin
            $display("sphere_surface_source_sampler_top_test: done, errors");
        end
        $finish;
    end

endmodule
